FILE: design/cetb_pkg.sv
// Shared types and constants for the cascaded elapsed timer bank.
// Used by cetb_ctrl, cetb_dpath and the top level; depends on nothing.
`default_nettype none

package cetb_pkg;

  // Bank size and counter width
  localparam int NUM_TIMERS  = 8;
  localparam int COUNT_WIDTH = 32;

  // Derived widths
  localparam int SLOT_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int FREE_W = $clog2(NUM_TIMERS + 1);

  // Fixed field widths of the words
  localparam int MODE_W   = 2;
  localparam int SLOTF_W  = 3;
  localparam int SCALE_W  = 3;
  localparam int STATUS_W = 2;
  localparam int OUTC_W   = 32;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REG   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_REGD = 2'd2;

  // Top unit codes
  localparam logic [SCALE_W-1:0] SCALE_MSEC = 3'd0;
  localparam logic [SCALE_W-1:0] SCALE_SEC  = 3'd1;
  localparam logic [SCALE_W-1:0] SCALE_MIN  = 3'd2;
  localparam logic [SCALE_W-1:0] SCALE_HOUR = 3'd3;
  localparam logic [SCALE_W-1:0] SCALE_DAY  = 3'd4;

  // Rollover limits: a unit carries once it passes these
  localparam logic [31:0] MSEC_LAST = 32'd999;
  localparam logic [31:0] SEC_LAST  = 32'd59;
  localparam logic [31:0] MIN_LAST  = 32'd59;
  localparam logic [31:0] HOUR_LAST = 32'd23;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;       // capture the input word
    logic walk_step;  // read slot at walk pointer, advance pointer
    logic rd_slot;    // read the addressed slot
    logic act;        // perform register or clear
    logic out_load;   // load the result register
  } cetb_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              walk_last;
    logic              out_free;
  } cetb_sts_t;

  // One slot's counts
  typedef struct packed {
    logic [COUNT_WIDTH-1:0] msec;
    logic [COUNT_WIDTH-1:0] sec;
    logic [COUNT_WIDTH-1:0] mins;
    logic [COUNT_WIDTH-1:0] hour;
    logic [COUNT_WIDTH-1:0] day;
  } cetb_cnt_t;

endpackage

`default_nettype wire

FILE: design/cetb_ctrl.sv
// Controller state machine of the timer bank: sequences each accepted word.
// Depends on cetb_pkg for command and status structs and mode codes.
`default_nettype none

module cetb_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire cetb_pkg::cetb_sts_t sts,
  output cetb_pkg::cetb_cmd_t      cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (sts.mode)
          cetb_pkg::MODE_TICK: begin
            state_nxt = ST_WALK;
          end
          cetb_pkg::MODE_READ: begin
            cmd.rd_slot = 1'b1;
            state_nxt   = ST_FIN;
          end
          cetb_pkg::MODE_REG, cetb_pkg::MODE_CLEAR: begin
            // act and answer in the same cycle, once the result slot frees
            if (sts.out_free) begin
              cmd.act      = 1'b1;
              cmd.out_load = 1'b1;
              state_nxt    = ST_IDLE;
            end
          end
        endcase
      end
      ST_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.walk_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_load_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == ST_EXEC)
    else $error("accepted word did not move controller to execute");

  a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK && sts.walk_last) |=> state_r == ST_FIN)
    else $error("tick walk did not finish after last slot");

  a_answer_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded while the result register is held");

endmodule

`default_nettype wire

FILE: design/cetb_dpath.sv
// Datapath of the timer bank: slot count and scale memories, in-use flags,
// tick walk pointer with advance logic, and the result register.
// Depends on cetb_pkg for widths, codes, limits and the command structs.
`default_nettype none

module cetb_dpath (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic [cetb_pkg::MODE_W-1:0]          in_mode,
  input  wire logic [cetb_pkg::SLOTF_W-1:0]         in_timer_slot,
  input  wire logic [cetb_pkg::SCALE_W-1:0]         in_scale,
  input  wire cetb_pkg::cetb_cmd_t                  cmd,
  output cetb_pkg::cetb_sts_t                       sts,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [cetb_pkg::STATUS_W-1:0]             out_status,
  output logic [cetb_pkg::SLOTF_W-1:0]              out_slot_out,
  output logic [cetb_pkg::OUTC_W-1:0]               out_msec_out,
  output logic [cetb_pkg::OUTC_W-1:0]               out_sec_out,
  output logic [cetb_pkg::OUTC_W-1:0]               out_min_out,
  output logic [cetb_pkg::OUTC_W-1:0]               out_hour_out,
  output logic [cetb_pkg::OUTC_W-1:0]               out_day_out
);

  localparam int SW = cetb_pkg::SLOT_W;
  localparam int FW = cetb_pkg::FREE_W;
  localparam int CW = cetb_pkg::COUNT_WIDTH;

  // Map the 3-bit slot field onto a memory index
  function automatic logic [SW-1:0] field_to_idx(input logic [cetb_pkg::SLOTF_W-1:0] s);
    logic [SW+cetb_pkg::SLOTF_W-1:0] ext;
    ext = {{SW{1'b0}}, s};
    return ext[SW-1:0];
  endfunction

  // Low bits of the free pointer as a slot field
  function automatic logic [cetb_pkg::SLOTF_W-1:0] free_to_field(input logic [FW-1:0] f);
    logic [FW+cetb_pkg::SLOTF_W-1:0] ext;
    ext = {{cetb_pkg::SLOTF_W{1'b0}}, f};
    return ext[cetb_pkg::SLOTF_W-1:0];
  endfunction

  // Captured word
  logic [cetb_pkg::MODE_W-1:0]  mode_r;
  logic [cetb_pkg::SLOTF_W-1:0] slot_r;
  logic [cetb_pkg::SCALE_W-1:0] scale_r;

  // Bank bookkeeping
  logic [cetb_pkg::NUM_TIMERS-1:0] in_use_r;
  logic [FW-1:0]                   next_free_r;

  // Memories and their registered read port
  cetb_pkg::cetb_cnt_t          cnt_mem [cetb_pkg::NUM_TIMERS];
  logic [cetb_pkg::SCALE_W-1:0] scl_mem [cetb_pkg::NUM_TIMERS];
  cetb_pkg::cetb_cnt_t          rd_cnt_r;
  logic [cetb_pkg::SCALE_W-1:0] rd_scl_r;

  // Tick walk
  logic [SW-1:0] walk_r;
  logic          wb_valid_r;
  logic [SW-1:0] wb_addr_r;

  // Result register
  logic                         out_valid_r;
  logic [cetb_pkg::STATUS_W-1:0] status_r;
  logic [cetb_pkg::SLOTF_W-1:0] slot_out_r;
  cetb_pkg::cetb_cnt_t          res_cnt_r;

  logic [SW-1:0]  slot_idx;
  logic [SW-1:0]  free_idx;
  logic [SW-1:0]  rd_addr;
  logic           slot_live;
  logic           bank_full;
  logic           out_free;
  logic           do_reg;
  logic           do_clr;
  logic           do_wb;

  // Advance logic signals
  logic                ge_sec, ge_min, ge_hour, ge_day;
  logic [CW-1:0]       ms_b, s_b, m_b, h_b, d_b;
  logic                c_ms, c_s, c_m, c_h;
  logic [CW-1:0]       s_v, m_v, h_v;
  cetb_pkg::cetb_cnt_t adv;

  assign slot_idx  = field_to_idx(slot_r);
  assign free_idx  = next_free_r[SW-1:0];
  assign slot_live = ({29'd0, slot_r} < 32'(cetb_pkg::NUM_TIMERS)) && in_use_r[slot_idx];
  assign bank_full = (next_free_r == FW'(cetb_pkg::NUM_TIMERS));
  assign out_free  = !out_valid_r || !out_stall;
  assign rd_addr   = cmd.walk_step ? walk_r : slot_idx;

  assign do_wb  = wb_valid_r && in_use_r[wb_addr_r];
  assign do_reg = cmd.act && (mode_r == cetb_pkg::MODE_REG) && !bank_full;
  assign do_clr = cmd.act && (mode_r == cetb_pkg::MODE_CLEAR) && slot_live;

  assign sts.mode      = mode_r;
  assign sts.walk_last = (walk_r == SW'(cetb_pkg::NUM_TIMERS - 1));
  assign sts.out_free  = out_free;

  // One millisecond advance of the slot just read; carries ripple from milliseconds upward
  always_comb begin
    ge_sec  = (rd_scl_r >= cetb_pkg::SCALE_SEC)  && (rd_scl_r <= cetb_pkg::SCALE_DAY);
    ge_min  = (rd_scl_r >= cetb_pkg::SCALE_MIN)  && (rd_scl_r <= cetb_pkg::SCALE_DAY);
    ge_hour = (rd_scl_r >= cetb_pkg::SCALE_HOUR) && (rd_scl_r <= cetb_pkg::SCALE_DAY);
    ge_day  = (rd_scl_r == cetb_pkg::SCALE_DAY);

    ms_b = rd_cnt_r.msec + CW'(1);
    s_b  = rd_cnt_r.sec  + CW'(1);
    m_b  = rd_cnt_r.mins + CW'(1);
    h_b  = rd_cnt_r.hour + CW'(1);
    d_b  = rd_cnt_r.day  + CW'(1);

    c_ms = ge_sec && (32'(ms_b) > cetb_pkg::MSEC_LAST);
    c_s  = ge_min && (c_ms ? (32'(s_b) > cetb_pkg::SEC_LAST)
                           : (32'(rd_cnt_r.sec) > cetb_pkg::SEC_LAST));
    c_m  = ge_hour && (c_s ? (32'(m_b) > cetb_pkg::MIN_LAST)
                           : (32'(rd_cnt_r.mins) > cetb_pkg::MIN_LAST));
    c_h  = ge_day && (c_m ? (32'(h_b) > cetb_pkg::HOUR_LAST)
                          : (32'(rd_cnt_r.hour) > cetb_pkg::HOUR_LAST));

    s_v = c_ms ? s_b : rd_cnt_r.sec;
    m_v = c_s  ? m_b : rd_cnt_r.mins;
    h_v = c_m  ? h_b : rd_cnt_r.hour;

    adv.msec = c_ms ? '0 : ms_b;
    adv.sec  = c_s  ? '0 : s_v;
    adv.mins = c_m  ? '0 : m_v;
    adv.hour = c_h  ? '0 : h_v;
    adv.day  = c_h  ? d_b : rd_cnt_r.day;
  end

  // Capture the word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_mode;
      slot_r  <= in_timer_slot;
      scale_r <= in_scale;
    end
  end

  // Memory write port: tick write-back, register or clear
  always_ff @(posedge clk) begin
    if (do_wb) begin
      cnt_mem[wb_addr_r] <= adv;
    end else if (do_reg) begin
      cnt_mem[free_idx] <= '0;
    end else if (do_clr) begin
      cnt_mem[slot_idx] <= '0;
    end
    if (do_reg) begin
      scl_mem[free_idx] <= scale_r;
    end
  end

  // Memory read port
  always_ff @(posedge clk) begin
    if (cmd.walk_step || cmd.rd_slot) begin
      rd_cnt_r <= cnt_mem[rd_addr];
      rd_scl_r <= scl_mem[rd_addr];
    end
  end

  // Bookkeeping and walk control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r    <= '0;
      next_free_r <= '0;
      walk_r      <= '0;
      wb_valid_r  <= 1'b0;
      wb_addr_r   <= '0;
    end else begin
      if (do_reg) begin
        in_use_r[free_idx] <= 1'b1;
        next_free_r        <= next_free_r + FW'(1);
      end
      if (cmd.load) begin
        walk_r <= '0;
      end else if (cmd.walk_step) begin
        walk_r <= walk_r + SW'(1);
      end
      wb_valid_r <= cmd.walk_step;
      wb_addr_r  <= walk_r;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status_r   <= cetb_pkg::STATUS_OK;
      slot_out_r <= '0;
      res_cnt_r  <= '0;
      unique case (mode_r)
        cetb_pkg::MODE_TICK: begin
        end
        cetb_pkg::MODE_REG: begin
          if (bank_full) begin
            status_r <= cetb_pkg::STATUS_FULL;
          end else begin
            slot_out_r <= free_to_field(next_free_r);
          end
        end
        cetb_pkg::MODE_CLEAR: begin
          slot_out_r <= slot_r;
          if (!slot_live) begin
            status_r <= cetb_pkg::STATUS_NOT_REGD;
          end
        end
        cetb_pkg::MODE_READ: begin
          slot_out_r <= slot_r;
          if (!slot_live) begin
            status_r <= cetb_pkg::STATUS_NOT_REGD;
          end else begin
            res_cnt_r <= rd_cnt_r;
          end
        end
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = status_r;
  assign out_slot_out = slot_out_r;
  assign out_msec_out = 32'(res_cnt_r.msec);
  assign out_sec_out  = 32'(res_cnt_r.sec);
  assign out_min_out  = 32'(res_cnt_r.mins);
  assign out_hour_out = 32'(res_cnt_r.hour);
  assign out_day_out  = 32'(res_cnt_r.day);

  a_wb_only_tick: assert property (@(posedge clk) disable iff (!rst_n)
    wb_valid_r |-> mode_r == cetb_pkg::MODE_TICK)
    else $error("write-back outside a tick");

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_free_r <= FW'(cetb_pkg::NUM_TIMERS))
    else $error("free pointer beyond bank size");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && out_stall))
    else $error("result register overwritten while held");

endmodule

`default_nettype wire

FILE: design/cascaded_elapsed_timer_bank_top.sv
// Top level of the cascaded elapsed timer bank: joins controller and datapath.
// Depends on cetb_pkg, cetb_ctrl and cetb_dpath.
//
//  channel  direction  handshake              payload
//  in_      input      in_valid / in_stall    in_mode, in_timer_slot, in_scale
//  out_     output     out_valid / out_stall  out_status, out_slot_out,
//                                             out_msec_out .. out_day_out
//
// A word is taken in the idle state; register and clear finish in the execute state,
// read in the finish state after it, and a tick in the finish state after the
// walk over the slot memory, one slot read and an earlier one written back per cycle.
// Synchronous active-low reset clears in-use flags, free pointer and control.
// A held result stalls only the completing step; the next word is accepted
// while a result waits in the output register.
`default_nettype none

module cascaded_elapsed_timer_bank_top (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [cetb_pkg::MODE_W-1:0]          in_mode,
  input  wire logic [cetb_pkg::SLOTF_W-1:0]         in_timer_slot,
  input  wire logic [cetb_pkg::SCALE_W-1:0]         in_scale,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [cetb_pkg::STATUS_W-1:0]             out_status,
  output logic [cetb_pkg::SLOTF_W-1:0]              out_slot_out,
  output logic [cetb_pkg::OUTC_W-1:0]               out_msec_out,
  output logic [cetb_pkg::OUTC_W-1:0]               out_sec_out,
  output logic [cetb_pkg::OUTC_W-1:0]               out_min_out,
  output logic [cetb_pkg::OUTC_W-1:0]               out_hour_out,
  output logic [cetb_pkg::OUTC_W-1:0]               out_day_out
);

  // Commands down to the datapath, status back up
  cetb_pkg::cetb_cmd_t cmd;
  cetb_pkg::cetb_sts_t sts;

  // Sequence each word: capture, dispatch on mode, walk on ticks, answer
  cetb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold the slot memories, advance counts, and drive the result word
  cetb_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mode       (in_mode),
    .in_timer_slot (in_timer_slot),
    .in_scale      (in_scale),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_slot_out  (out_slot_out),
    .out_msec_out  (out_msec_out),
    .out_sec_out   (out_sec_out),
    .out_min_out   (out_min_out),
    .out_hour_out  (out_hour_out),
    .out_day_out   (out_day_out)
  );

endmodule

`default_nettype wire
